/* rtl/ejseg_pkg.sv */
`default_nettype none
package ejseg_pkg;

	// String length bound; offsets and totals saturate below it
	localparam int MAX_LINE_BYTES = 4096;
	localparam int CNT_W = 12;
	localparam logic [CNT_W-1:0] SAT_MAX = (MAX_LINE_BYTES - 1) < 4095 ?
		CNT_W'(MAX_LINE_BYTES - 1) : CNT_W'(4095);

	// Byte classes
	localparam logic [7:0] BYTE_NUL      = 8'h00;
	localparam logic [7:0] BYTE_HIGH     = 8'h80;
	localparam logic [7:0] BYTE_SS2      = 8'h8E;
	localparam logic [7:0] BYTE_SS3      = 8'h8F;
	localparam logic [7:0] BYTE_TRAIL_LO = 8'hA1;
	localparam logic [7:0] BYTE_KANA_HI  = 8'hDF;
	localparam logic [7:0] BYTE_TRAIL_HI = 8'hFE;

	// Register indexes on the APB port
	localparam logic REG_BYTE_LIMIT   = 1'b0;
	localparam logic REG_COLUMN_LIMIT = 1'b1;
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(4095);

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int MAX_PUSH = 3;

	typedef struct packed {
		logic             has_char;
		logic [CNT_W-1:0] start_offset;
		logic [1:0]       char_len;
		logic [1:0]       char_width;
		logic             is_complete;
		logic [CNT_W-1:0] char_total;
		logic [CNT_W-1:0] column_total;
		logic [CNT_W-1:0] bytes_kept;
		logic [CNT_W-1:0] cols_kept_bytes;
		logic             run_end;
		logic             string_end;
	} res_t;

	typedef struct packed {
		logic [1:0]       cnt;
		res_t [MAX_PUSH-1:0] res;
	} push_t;

endpackage
`default_nettype wire

/* rtl/ejseg_byte_if.sv */
`default_nettype none
interface ejseg_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source(output valid, output text_byte, output final_byte, input ready);
	modport sink(input valid, input text_byte, input final_byte, output ready);
endinterface
`default_nettype wire

/* rtl/ejseg_char_if.sv */
`default_nettype none
interface ejseg_char_if;
	import ejseg_pkg::*;
	logic             valid;
	logic             ready;
	logic             has_char;
	logic [CNT_W-1:0] start_offset;
	logic [1:0]       char_len;
	logic [1:0]       char_width;
	logic             is_complete;
	logic [CNT_W-1:0] char_total;
	logic [CNT_W-1:0] column_total;
	logic [CNT_W-1:0] bytes_kept;
	logic [CNT_W-1:0] cols_kept_bytes;
	logic             run_end;
	logic             string_end;

	modport source(output valid, output has_char, output start_offset, output char_len,
		output char_width, output is_complete, output char_total, output column_total,
		output bytes_kept, output cols_kept_bytes, output run_end, output string_end,
		input ready);
	modport sink(input valid, input has_char, input start_offset, input char_len,
		input char_width, input is_complete, input char_total, input column_total,
		input bytes_kept, input cols_kept_bytes, input run_end, input string_end,
		output ready);
endinterface
`default_nettype wire

/* rtl/ejseg_apb_regs.sv */
`default_nettype none
module ejseg_apb_regs
	import ejseg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	output logic      [CNT_W-1:0] byte_limit,
	output logic      [CNT_W-1:0] column_limit
);

	logic [CNT_W-1:0] byte_limit_q;
	logic [CNT_W-1:0] column_limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q   <= LIMIT_RESET;
			column_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_BYTE_LIMIT:   byte_limit_q   <= pwdata[CNT_W-1:0];
				REG_COLUMN_LIMIT: column_limit_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BYTE_LIMIT:   prdata = 32'(byte_limit_q);
			REG_COLUMN_LIMIT: prdata = 32'(column_limit_q);
			default:          prdata = '0;
		endcase
	end

	// paddr[1:0] select bytes within a word and do not decode
	logic unused_addr;
	assign unused_addr = ^paddr[1:0];

	assign byte_limit   = byte_limit_q;
	assign column_limit = column_limit_q;

endmodule
`default_nettype wire

/* rtl/ejseg_core.sv */
`default_nettype none
module ejseg_core
	import ejseg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       text_byte,
	input  wire logic             final_byte,
	input  wire logic [CNT_W-1:0] byte_limit,
	input  wire logic [CNT_W-1:0] column_limit,
	output logic                  busy_s1,
	output push_t                 push
);

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	typedef struct packed {
		logic [1:0] len;
		logic [1:0] width;
		logic       complete;
	} emit_t;

	localparam emit_t E_ASCII = '{len: 2'd1, width: 2'd1, complete: 1'b1};
	localparam emit_t E_BAD   = '{len: 2'd1, width: 2'd1, complete: 1'b0};
	localparam emit_t E_KANA  = '{len: 2'd2, width: 2'd1, complete: 1'b1};
	localparam emit_t E_PAIR  = '{len: 2'd2, width: 2'd2, complete: 1'b1};
	localparam emit_t E_SS3   = '{len: 2'd3, width: 2'd2, complete: 1'b1};

	typedef struct packed {
		logic [1:0] count;
		logic [7:0] lead;
		logic [7:0] second;
	} pend_t;

	typedef struct packed {
		logic  emit;
		emit_t e;
		pend_t p;
		logic  done;
		logic  term;
	} step_t;

	typedef struct packed {
		logic [CNT_W-1:0] offset;
		logic [CNT_W-1:0] chars;
		logic [CNT_W-1:0] cols;
		logic [CNT_W-1:0] byte_cut;
		logic [CNT_W-1:0] col_cut_len;
		logic [CNT_W-1:0] col_cut_w;
		logic             byte_stop;
		logic             col_stop;
	} cnt_t;

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, SAT_MAX}) ? SAT_MAX : s[CNT_W-1:0];
	endfunction

	// One decoder pass over a byte; an unfinished pass drops a lead and reexamines it
	function automatic step_t feed_step(pend_t p, logic [7:0] b);
		step_t r;
		logic  trail_ok;
		r = '0;
		r.p = p;
		trail_ok = (b >= BYTE_TRAIL_LO) && (b <= BYTE_TRAIL_HI);
		case (p.count)
			PEND_NONE: begin
				r.done = 1'b1;
				if (b == BYTE_NUL) begin
					r.term = 1'b1;
				end else if (b < BYTE_HIGH) begin
					r.emit = 1'b1;
					r.e = E_ASCII;
				end else if (b == BYTE_SS2 || b == BYTE_SS3 || trail_ok) begin
					r.p.lead = b;
					r.p.count = PEND_ONE;
				end else begin
					r.emit = 1'b1;
					r.e = E_BAD;
				end
			end
			PEND_ONE: begin
				if (p.lead == BYTE_SS2) begin
					if (b >= BYTE_TRAIL_LO && b <= BYTE_KANA_HI) begin
						r.done = 1'b1;
						r.emit = 1'b1;
						r.e = E_KANA;
					end
				end else if (p.lead == BYTE_SS3) begin
					if (trail_ok) begin
						r.done = 1'b1;
						r.p.second = b;
						r.p.count = PEND_TWO;
					end
				end else if (trail_ok) begin
					r.done = 1'b1;
					r.emit = 1'b1;
					r.e = E_PAIR;
				end
				if (!r.done) begin
					r.emit = 1'b1;
					r.e = E_BAD;
				end
				if (r.emit)
					r.p.count = PEND_NONE;
			end
			default: begin
				r.emit = 1'b1;
				if (trail_ok) begin
					r.done = 1'b1;
					r.e = E_SS3;
					r.p.count = PEND_NONE;
				end else begin
					// drop the SS3 lead, retry with the held second byte as lead
					r.e = E_BAD;
					r.p.lead = p.second;
					r.p.count = PEND_ONE;
				end
			end
		endcase
		return r;
	endfunction

	function automatic cnt_t apply_emit(cnt_t c, emit_t e, logic [CNT_W-1:0] blim,
			logic [CNT_W-1:0] clim);
		cnt_t           n;
		logic [CNT_W:0] bsum;
		logic [CNT_W:0] csum;
		n = c;
		n.offset = sat_add(c.offset, CNT_W'(e.len));
		n.chars  = sat_add(c.chars, CNT_W'(1));
		n.cols   = sat_add(c.cols, CNT_W'(e.width));
		bsum = {1'b0, c.byte_cut} + (CNT_W+1)'(e.len);
		csum = {1'b0, c.col_cut_w} + (CNT_W+1)'(e.width);
		if (!c.byte_stop) begin
			if (!e.complete || bsum > {1'b0, blim})
				n.byte_stop = 1'b1;
			else
				n.byte_cut = bsum[CNT_W-1:0];
		end
		if (!c.col_stop) begin
			if (!e.complete || csum > {1'b0, clim})
				n.col_stop = 1'b1;
			else begin
				n.col_cut_w = csum[CNT_W-1:0];
				// byte length of the column prefix wraps at the field width
				n.col_cut_len = c.col_cut_len + CNT_W'(e.len);
			end
		end
		return n;
	endfunction

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	pend_t pend_q, pend_d;
	cnt_t  cnt_q, cnt_d;
	logic  ended_q, ended_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			fin_s1  <= final_byte;
		end
	end

	always_comb begin
		pend_t      p;
		step_t      r;
		cnt_t       c;
		logic       phase;
		logic       run;
		logic       ended;
		logic [1:0] nem;
		logic [1:0] nres;
		emit_t      em [MAX_PUSH];
		res_t       rs [MAX_PUSH];
		logic [CNT_W-1:0] start;

		p = pend_q;
		r = '0;
		c = cnt_q;
		phase = 1'b0;
		run = 1'b1;
		ended = 1'b0;
		nem = '0;
		nres = '0;
		start = '0;
		for (int k = 0; k < MAX_PUSH; k++) begin
			em[k] = '0;
			rs[k] = '0;
		end

		// decode the byte, then a virtual terminator when the string is marked final
		for (int i = 0; i < 6; i++) begin
			if (run) begin
				r = feed_step(p, phase ? BYTE_NUL : byte_s1);
				if (r.emit && nem != 2'd3) begin
					em[nem] = r.e;
					nem = nem + 2'd1;
				end
				p = r.p;
				if (r.done) begin
					if (r.term) begin
						ended = 1'b1;
						run = 1'b0;
					end else if (fin_s1 && !phase)
						phase = 1'b1;
					else
						run = 1'b0;
				end
			end
		end

		// advance counters and cut lengths through each emitted character
		for (int k = 0; k < MAX_PUSH; k++) begin
			if (2'(k) < nem) begin
				start = c.offset;
				c = apply_emit(c, em[k], byte_limit, column_limit);
				rs[k].has_char        = 1'b1;
				rs[k].start_offset    = start;
				rs[k].char_len        = em[k].len;
				rs[k].char_width      = em[k].width;
				rs[k].is_complete     = em[k].complete;
				rs[k].char_total      = c.chars;
				rs[k].column_total    = c.cols;
				rs[k].bytes_kept      = c.byte_cut;
				rs[k].cols_kept_bytes = c.col_cut_len;
			end
		end
		nres = nem;
		if (ended && nem == 2'd0) begin
			rs[0].start_offset    = c.offset;
			rs[0].char_total      = c.chars;
			rs[0].column_total    = c.cols;
			rs[0].bytes_kept      = c.byte_cut;
			rs[0].cols_kept_bytes = c.col_cut_len;
			nres = 2'd1;
		end
		if (nres != 2'd0) begin
			rs[nres - 2'd1].run_end    = 1'b1;
			rs[nres - 2'd1].string_end = ended;
		end

		pend_d = pend_q;
		cnt_d = cnt_q;
		ended_d = ended_q;
		push.cnt = '0;
		for (int k = 0; k < MAX_PUSH; k++)
			push.res[k] = rs[k];

		if (valid_s1) begin
			if (ended_q) begin
				// skip bytes after a terminator until the final byte
				if (fin_s1) begin
					pend_d = '0;
					cnt_d = '0;
					ended_d = 1'b0;
				end
			end else if (ended) begin
				push.cnt = nres;
				pend_d = '0;
				cnt_d = '0;
				ended_d = !fin_s1;
			end else begin
				push.cnt = nres;
				pend_d = p;
				cnt_d = c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			cnt_q   <= '0;
			ended_q <= 1'b0;
		end else begin
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
			ended_q <= ended_d;
		end
	end

	assign busy_s1 = valid_s1;

endmodule
`default_nettype wire

/* rtl/ejseg_fifo.sv */
`default_nettype none
module ejseg_fifo
	import ejseg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire push_t             push,
	ejseg_char_if.source           chars,
	output logic      [FILL_W-1:0] fill
);

	res_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              pop;
	res_t              head;

	assign pop = chars.valid && chars.ready;

	// up to three entries land per cycle; the caller keeps room for them
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_PUSH; k++) begin
			if (2'(k) < push.cnt)
				mem_q[wr_ptr_q + PTR_W'(k)] <= push.res[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			fill_q <= fill_q + FILL_W'(push.cnt) - FILL_W'(pop);
		end
	end

	assign head = mem_q[rd_ptr_q];

	assign chars.valid           = (fill_q != '0);
	assign chars.has_char        = head.has_char;
	assign chars.start_offset    = head.start_offset;
	assign chars.char_len        = head.char_len;
	assign chars.char_width      = head.char_width;
	assign chars.is_complete     = head.is_complete;
	assign chars.char_total      = head.char_total;
	assign chars.column_total    = head.column_total;
	assign chars.bytes_kept      = head.bytes_kept;
	assign chars.cols_kept_bytes = head.cols_kept_bytes;
	assign chars.run_end         = head.run_end;
	assign chars.string_end      = head.string_end;

	assign fill = fill_q;

endmodule
`default_nettype wire

/* rtl/euc_jp_char_segmenter.sv */
// EUC-JP character segmenter.
// bytes: one string byte per transaction (text_byte, final_byte); a zero
//   byte ends the string, final_byte closes it even without one.
// chars: one transaction per character found, or a bare end marker
//   (has_char 0) when a string ends on a step with no character;
//   run_end marks the last one caused by an input byte, string_end the
//   last one of the string.
// APB: byte_limit at 0x0, column_limit at 0x4; write only while idle.
// Flow: a byte is registered on acceptance, decoded and counted in the
//   next cycle, and its results are then written into the result queue.
// Throughput: one byte per cycle while bytes.ready is high. A byte can
//   cause up to three results; they drain through an eight-entry result
//   queue; bytes is held off without room for three per byte in flight.
// Stall: a stalled receiver fills the queue, then bytes.ready drops;
//   nothing is lost or reordered.
// Reset: limits return to 4095, all string state and the queue clear.
`default_nettype none
module euc_jp_char_segmenter
	import ejseg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	ejseg_byte_if.sink       bytes,
	ejseg_char_if.source     chars,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [CNT_W-1:0]  byte_limit;
	logic [CNT_W-1:0]  column_limit;
	logic              busy_s1;
	push_t             push;
	logic [FILL_W-1:0] fill;
	logic              accept;

	ejseg_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.byte_limit   (byte_limit),
		.column_limit (column_limit)
	);

	// Room check: the byte in decode may still add three entries, and the
	// new byte three more, with no pops assumed.
	assign bytes.ready = ((FILL_W+1)'(fill) + (busy_s1 ? (FILL_W+1)'(MAX_PUSH) : '0))
		<= (FILL_W+1)'(FIFO_DEPTH - MAX_PUSH);
	assign accept = bytes.valid && bytes.ready;

	ejseg_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_byte    (bytes.text_byte),
		.final_byte   (bytes.final_byte),
		.byte_limit   (byte_limit),
		.column_limit (column_limit),
		.busy_s1      (busy_s1),
		.push         (push)
	);

	ejseg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.chars  (chars),
		.fill   (fill)
	);

endmodule
`default_nettype wire
